### rtl/core/psa_pkg.sv
// Shared codes and the neighbor offset table for the pixel sample accumulator.
`timescale 1ns / 1ps

package psa_pkg;

  // Operation codes
  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_NBR   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // Neighbor pattern codes (the unused code also means all eight)
  localparam logic [1:0] PAT_ORTHO = 2'd0;
  localparam logic [1:0] PAT_DIAG  = 2'd1;
  localparam logic [1:0] PAT_ALL   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'd1;
  localparam int CFG_DATA_BITS = 9;

  // Offset codes for one axis
  typedef logic [1:0] offset_t;
  localparam offset_t OFF_NEG  = 2'b11;
  localparam offset_t OFF_ZERO = 2'b00;
  localparam offset_t OFF_POS  = 2'b01;

  typedef struct packed {
    offset_t dy;
    offset_t dx;
  } nbr_off_t;

  // Eight neighbors, row by row
  function automatic nbr_off_t nbr_offset(input logic [2:0] k);
    nbr_off_t o;
    case (k)
      3'd0:    o = '{dy: OFF_NEG,  dx: OFF_NEG};
      3'd1:    o = '{dy: OFF_NEG,  dx: OFF_ZERO};
      3'd2:    o = '{dy: OFF_NEG,  dx: OFF_POS};
      3'd3:    o = '{dy: OFF_ZERO, dx: OFF_NEG};
      3'd4:    o = '{dy: OFF_ZERO, dx: OFF_POS};
      3'd5:    o = '{dy: OFF_POS,  dx: OFF_NEG};
      3'd6:    o = '{dy: OFF_POS,  dx: OFF_ZERO};
      default: o = '{dy: OFF_POS,  dx: OFF_POS};
    endcase
    return o;
  endfunction

endpackage

### rtl/core/psa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/psa_div.sv
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
`timescale 1ns / 1ps

module psa_div #(
  parameter int DB = 16,  // divisor bits
  parameter int QB = 16   // quotient bits
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DB+QB-1:0]   dividend [0:2],
  input  logic [DB-1:0]      divisor,
  output logic               done,
  output logic [QB-1:0]      quot [0:2]
);

  localparam int CW = $clog2(QB + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DB-1:0] dvs_r;
  logic [DB-1:0] rem_r [0:2];
  logic [QB-1:0] low_r [0:2];
  logic [DB-1:0] rem_nxt [0:2];
  logic [QB-1:0] low_nxt [0:2];

  // One trial subtract per lane; quotient is known to fit in QB bits
  always_comb begin
    logic [DB:0] t;
    logic        ge;
    for (int c = 0; c < 3; c++) begin
      t  = {rem_r[c], low_r[c][QB-1]};
      ge = (t >= {1'b0, dvs_r});
      rem_nxt[c] = ge ? DB'(t - {1'b0, dvs_r}) : DB'(t);
      low_nxt[c] = {low_r[c][QB-2:0], ge};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QB);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= dividend[c][DB+QB-1:QB];
        low_r[c] <= dividend[c][QB-1:0];
      end
    end else if (busy_r) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= rem_nxt[c];
        low_r[c] <= low_nxt[c];
      end
    end
  end

  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 3; c++) quot[c] = low_r[c];
  end

  // Done only ever follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule

### rtl/core/pixel_sample_accumulator.sv
// Per-pixel progressive accumulation buffer: top level and sequencer.
`timescale 1ns / 1ps

// One item is handled at a time. After reset the pixel store is swept to
// zero, one entry a cycle, with in_ready low (configuration writes are
// taken during the sweep). The time of an accumulate is set by the
// bit-serial divider (one quotient bit a cycle for the three channels
// together), skipped when the count is saturated; the neighbor average is
// also set by the single read port of the pixel store, read once per
// neighbor, and skips the divider with no neighbor in bounds. A new
// item is taken while the previous result still waits on out_ready.

module pixel_sample_accumulator
  import psa_pkg::*;
#(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int COUNT_BITS   = 16,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_operation,
  input  logic [7:0]               in_x_coord,
  input  logic [7:0]               in_y_coord,
  input  logic [15:0]              in_sample_red,
  input  logic [15:0]              in_sample_green,
  input  logic [15:0]              in_sample_blue,
  input  logic [1:0]               in_neighbor_pattern,
  // results
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_red,
  output logic [15:0]              out_green,
  output logic [15:0]              out_blue,
  output logic [1:0]               out_status
);

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int CB     = CHANNEL_BITS;
  localparam int NB     = COUNT_BITS;
  localparam int SB     = CB + NB;        // sum bits
  localparam int ACB    = CB + 3;         // neighbor sum bits
  localparam int WB     = 3 * CB + 3 * SB + NB;
  localparam int SUM_LO = 3 * CB;
  localparam int CNT_LO = 3 * CB + 3 * SB;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RDWAIT  = 4'd2;
  localparam logic [3:0] ST_NBR     = 4'd3;
  localparam logic [3:0] ST_NBRLAST = 4'd4;
  localparam logic [3:0] ST_NBRFIN  = 4'd5;
  localparam logic [3:0] ST_DIV     = 4'd6;
  localparam logic [3:0] ST_RESULT  = 4'd7;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [8:0]    width_r, height_r;
  logic [1:0]    op_r, pat_r;
  logic [7:0]    x_r, y_r;
  logic [CB-1:0] smp_r [0:2];
  logic [AW-1:0] addr_r;
  logic [2:0]    nbr_k_r;
  logic          nbr_pend_r;
  logic [ACB-1:0] acc_r [0:2];
  logic [3:0]    total_r;
  logic [SB-1:0] new_sum_r [0:2];
  logic [NB-1:0] new_cnt_r;
  logic [CB-1:0] res_r [0:2];
  logic [1:0]    res_stat_r;
  logic          out_valid_r;
  logic [15:0]   out_red_r, out_green_r, out_blue_r;
  logic [1:0]    out_status_r;

  // Effective image size
  logic [8:0] w_eff, h_eff;
  always_comb begin
    if (width_r == 9'd0) w_eff = 9'd1;
    else if (32'(width_r) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == 9'd0) h_eff = 9'd1;
    else if (32'(height_r) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
    else h_eff = height_r;
  end

  // Address of the incoming pixel, row flipped
  logic          in_rng;
  logic [8:0]    in_row;
  logic [AW-1:0] in_addr;
  assign in_rng  = (9'(in_x_coord) < w_eff) && (9'(in_y_coord) < h_eff);
  assign in_row  = h_eff - 9'd1 - 9'(in_y_coord);
  assign in_addr = AW'(32'(in_row) * MAX_WIDTH + 32'(in_x_coord));

  // Current neighbor: offset, bounds, pattern and address
  nbr_off_t      off;
  logic [8:0]    x9, y9, nx, ny, nrow;
  logic          n_inb, n_en, n_rd;
  logic [AW-1:0] n_addr;
  always_comb begin
    off = nbr_offset(nbr_k_r);
    x9  = 9'(x_r);
    y9  = 9'(y_r);
    nx  = (off.dx == OFF_NEG) ? x9 - 9'd1 : (off.dx == OFF_POS) ? x9 + 9'd1 : x9;
    ny  = (off.dy == OFF_NEG) ? y9 - 9'd1 : (off.dy == OFF_POS) ? y9 + 9'd1 : y9;
    n_inb = !((off.dx == OFF_NEG) && (x_r == 8'd0)) && (nx < w_eff) &&
            !((off.dy == OFF_NEG) && (y_r == 8'd0)) && (ny < h_eff);
    case (pat_r)
      PAT_ORTHO: n_en = (off.dx == OFF_ZERO) || (off.dy == OFF_ZERO);
      PAT_DIAG:  n_en = (off.dx != OFF_ZERO) && (off.dy != OFF_ZERO);
      default:   n_en = 1'b1;
    endcase
    n_rd   = (state_r == ST_NBR) && n_en && n_inb;
    nrow   = h_eff - 9'd1 - ny;
    n_addr = AW'(32'(nrow) * MAX_WIDTH + 32'(nx));
  end

  // Pixel store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0] ram_wdata, ram_rdata;
  logic          in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  logic [NB-1:0] rd_cnt;
  logic [SB-1:0] rd_sum  [0:2];
  logic [CB-1:0] rd_mean [0:2];
  logic [SB-1:0] sum_inc [0:2];
  logic          rd_sat;
  always_comb begin
    rd_cnt = ram_rdata[CNT_LO +: NB];
    for (int c = 0; c < 3; c++) begin
      rd_sum[c]  = ram_rdata[SUM_LO + c * SB +: SB];
      rd_mean[c] = ram_rdata[c * CB +: CB];
      sum_inc[c] = rd_sum[c] + SB'(smp_r[c]);
    end
    rd_sat = (rd_cnt == {NB{1'b1}});
  end

  // Divider
  logic          div_start, div_done;
  logic [SB-1:0] div_dvd [0:2];
  logic [NB-1:0] div_dvs;
  logic [CB-1:0] div_q   [0:2];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      div_dvd[c] = (state_r == ST_RDWAIT) ? sum_inc[c] : SB'(acc_r[c]);
    end
    div_dvs   = (state_r == ST_RDWAIT) ? rd_cnt + NB'(1) : NB'(total_r);
    div_start = ((state_r == ST_RDWAIT) && (op_r == OP_ACCUM) && !rd_sat) ||
                ((state_r == ST_NBRFIN) && (total_r != 4'd0));
  end

  psa_div #(.DB(NB), .QB(CB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q)
  );

  // Store port control: clearing sweep, write-back, reads
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
    end else if ((state_r == ST_DIV) && div_done && (op_r == OP_ACCUM)) begin
      ram_we = 1'b1;
      ram_wdata[CNT_LO +: NB] = new_cnt_r;
      for (int c = 0; c < 3; c++) begin
        ram_wdata[SUM_LO + c * SB +: SB] = new_sum_r[c];
        ram_wdata[c * CB +: CB]          = div_q[c];
      end
    end
    ram_re    = n_rd || (in_xfer && in_rng &&
                         ((in_operation == OP_ACCUM) || (in_operation == OP_READ)));
    ram_raddr = (state_r == ST_NBR) ? n_addr : in_addr;
  end

  psa_ram #(.WIDTH(WB), .DEPTH(PIXELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_addr_r == AW'(PIXELS - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          if (!in_rng || (in_operation != OP_ACCUM && in_operation != OP_READ &&
                          in_operation != OP_NBR)) begin
            state_nxt = ST_RESULT;
          end else if (in_operation == OP_NBR) begin
            state_nxt = ST_NBR;
          end else begin
            state_nxt = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT:  state_nxt = div_start ? ST_DIV : ST_RESULT;
      ST_NBR:     if (nbr_k_r == 3'd7) state_nxt = ST_NBRLAST;
      ST_NBRLAST: state_nxt = ST_NBRFIN;
      ST_NBRFIN:  state_nxt = div_start ? ST_DIV : ST_RESULT;
      ST_DIV:     if (div_done) state_nxt = ST_RESULT;
      ST_RESULT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      width_r     <= 9'd256;
      height_r    <= 9'd256;
      out_valid_r <= 1'b0;
      nbr_pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data;
          default:    ;
        endcase
      end
      nbr_pend_r <= n_rd;
      if ((state_r == ST_RESULT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_operation;
      pat_r    <= in_neighbor_pattern;
      x_r      <= in_x_coord;
      y_r      <= in_y_coord;
      addr_r   <= in_addr;
      smp_r[0] <= CB'(in_sample_red);
      smp_r[1] <= CB'(in_sample_green);
      smp_r[2] <= CB'(in_sample_blue);
      nbr_k_r  <= 3'd0;
      total_r  <= 4'd0;
      for (int c = 0; c < 3; c++) begin
        acc_r[c] <= '0;
        res_r[c] <= '0;
      end
      // unused operation reports ok whatever the coordinates
      if (in_operation != OP_ACCUM && in_operation != OP_READ &&
          in_operation != OP_NBR) begin
        res_stat_r <= STAT_OK;
      end else begin
        res_stat_r <= in_rng ? STAT_OK : STAT_RANGE;
      end
    end

    // Neighbor walk; read data lands in the cycle after the request
    if (state_r == ST_NBR) nbr_k_r <= nbr_k_r + 3'd1;
    if (nbr_pend_r && (state_r == ST_NBR || state_r == ST_NBRLAST)) begin
      total_r <= total_r + 4'd1;
      for (int c = 0; c < 3; c++) acc_r[c] <= acc_r[c] + ACB'(rd_mean[c]);
    end

    // Read, saturated accumulate, or start of a division
    if (state_r == ST_RDWAIT) begin
      new_cnt_r <= rd_cnt + NB'(1);
      for (int c = 0; c < 3; c++) begin
        new_sum_r[c] <= sum_inc[c];
        res_r[c]     <= rd_mean[c];
      end
      res_stat_r <= ((op_r == OP_ACCUM) && rd_sat) ? STAT_SAT : STAT_OK;
    end

    if ((state_r == ST_DIV) && div_done) begin
      for (int c = 0; c < 3; c++) res_r[c] <= div_q[c];
    end

    // Output register
    if ((state_r == ST_RESULT) && (!out_valid_r || out_ready)) begin
      out_red_r    <= 16'(res_r[0]);
      out_green_r  <= 16'(res_r[1]);
      out_blue_r   <= 16'(res_r[2]);
      out_status_r <= res_stat_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_red    = out_red_r;
  assign out_green  = out_green_r;
  assign out_blue   = out_blue_r;
  assign out_status = out_status_r;

  // Store writes only during the sweep or at the end of an accumulate
  a_write_when: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) || (state_r == ST_DIV))
    else $error("pixel store written outside sweep or write-back");

  // Divider finishes only while the sequencer waits on it
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside divide state");

  // A new result shows up only from the result state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RESULT)
    else $error("result valid without result state");

  // Never more than eight neighbors
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NBRFIN) |-> (total_r <= 4'd8))
    else $error("neighbor count above eight");

endmodule

### bench/psa_checker.sv
// Result predictor and scoreboard for the pixel sample accumulator.
`timescale 1ns / 1ps

module psa_checker
  import psa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               in_operation,
  input  logic [7:0]               in_x_coord,
  input  logic [7:0]               in_y_coord,
  input  logic [15:0]              in_sample_red,
  input  logic [15:0]              in_sample_green,
  input  logic [15:0]              in_sample_blue,
  input  logic [1:0]               in_neighbor_pattern,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [15:0]              out_red,
  input  logic [15:0]              out_green,
  input  logic [15:0]              out_blue,
  input  logic [1:0]               out_status,
  output int                       fail_count,
  output int                       pending
);

  localparam int ROW_PITCH = 256;
  localparam int PIXELS    = 65536;
  localparam logic [15:0] COUNT_FULL = 16'hFFFF;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [1:0]  status;
  } pixel_result_t;

  // Shadow of the pixel store and the size registers
  bit [31:0] sum_r [PIXELS];
  bit [31:0] sum_g [PIXELS];
  bit [31:0] sum_b [PIXELS];
  bit [15:0] n_samples [PIXELS];
  bit [15:0] avg_r [PIXELS];
  bit [15:0] avg_g [PIXELS];
  bit [15:0] avg_b [PIXELS];
  logic [8:0] width_reg;
  logic [8:0] height_reg;

  pixel_result_t awaited_q[$];

  function automatic int clamp_size(logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // Store index with the row flipped (y counts from the bottom)
  function automatic int pixel_addr(int x, int y);
    return (clamp_size(height_reg) - 1 - y) * ROW_PITCH + x;
  endfunction

  function automatic pixel_result_t predict_pixel(logic [1:0] op, int x, int y,
                                                  logic [15:0] sr, logic [15:0] sg,
                                                  logic [15:0] sb, logic [1:0] pat);
    pixel_result_t res;
    int w, h, a, nx, ny, total;
    bit [31:0] tr, tg, tb;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    res = '{red: '0, green: '0, blue: '0, status: STAT_OK};
    if (op != OP_ACCUM && op != OP_READ && op != OP_NBR) return res;
    if (x >= w || y >= h) begin
      res.status = STAT_RANGE;
      return res;
    end
    a = pixel_addr(x, y);
    if (op == OP_NBR) begin
      tr = 0; tg = 0; tb = 0; total = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          if (dx == 0 && dy == 0) continue;
          if (pat == PAT_ORTHO && dx != 0 && dy != 0) continue;
          if (pat == PAT_DIAG && (dx == 0 || dy == 0)) continue;
          nx = x + dx;
          ny = y + dy;
          if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
          tr += avg_r[pixel_addr(nx, ny)];
          tg += avg_g[pixel_addr(nx, ny)];
          tb += avg_b[pixel_addr(nx, ny)];
          total++;
        end
      end
      // no neighbor in bounds gives zero
      if (total != 0) begin
        res.red   = 16'(tr / total);
        res.green = 16'(tg / total);
        res.blue  = 16'(tb / total);
      end
      return res;
    end
    if (op == OP_ACCUM) begin
      if (n_samples[a] == COUNT_FULL) begin
        res.status = STAT_SAT;
      end else begin
        sum_r[a] += sr;
        sum_g[a] += sg;
        sum_b[a] += sb;
        n_samples[a] += 1;
        avg_r[a] = 16'(sum_r[a] / n_samples[a]);
        avg_g[a] = 16'(sum_g[a] / n_samples[a]);
        avg_b[a] = 16'(sum_b[a] / n_samples[a]);
      end
    end
    res.red   = avg_r[a];
    res.green = avg_g[a];
    res.blue  = avg_b[a];
    return res;
  endfunction

  function automatic int field_diff(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v === act_v) return 0;
    $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    return 1;
  endfunction

  // Watch all three channels; predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t fresh;
    if (!rst_n) begin
      width_reg  = 9'd256;
      height_reg = 9'd256;
      for (int i = 0; i < PIXELS; i++) begin
        sum_r[i] = 0; sum_g[i] = 0; sum_b[i] = 0; n_samples[i] = 0;
        avg_r[i] = 0; avg_g[i] = 0; avg_b[i] = 0;
      end
      awaited_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else if (cfg_index == CFG_HEIGHT) height_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        fresh = predict_pixel(in_operation, int'(in_x_coord), int'(in_y_coord),
                              in_sample_red, in_sample_green, in_sample_blue,
                              in_neighbor_pattern);
        awaited_q = {awaited_q, fresh};
      end
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          fail_count += field_diff("out_red", want.red, out_red);
          fail_count += field_diff("out_green", want.green, out_green);
          fail_count += field_diff("out_blue", want.blue, out_blue);
          fail_count += field_diff("out_status", 16'(want.status), 16'(out_status));
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

### bench/tb.sv
// Stimulus, pacing and verdict for the pixel sample accumulator testbench.
`timescale 1ns / 1ps

module tb
  import psa_pkg::*;
();

  localparam int LIMIT       = 4_000_000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_ACCUM;
  logic [7:0] in_x_coord = '0;
  logic [7:0] in_y_coord = '0;
  logic [15:0] in_sample_red = '0;
  logic [15:0] in_sample_green = '0;
  logic [15:0] in_sample_blue = '0;
  logic [1:0] in_neighbor_pattern = PAT_ORTHO;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_red, out_green, out_blue;
  logic [1:0] out_status;

  int fail_count;
  int pending;
  int cycles = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int burst_left = 0;
  int stall_hold = 0;
  int cur_w = 256;
  int cur_h = 256;

  pixel_sample_accumulator u_top (.*);

  psa_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: ready held in random stretches while stalling is on
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_hold == 0) begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      stall_hold = $urandom_range(1, 6);
    end else begin
      stall_hold--;
    end
  end

  function automatic int clamp_size(int v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drain all results, let the block settle, then resize
  task automatic resize(int w, int h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cur_w = clamp_size(w);
    cur_h = clamp_size(h);
  endtask

  task automatic send(logic [1:0] op, int x, int y, logic [15:0] r, logic [15:0] g,
                      logic [15:0] b, logic [1:0] pat);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_x_coord          <= x[7:0];
    in_y_coord          <= y[7:0];
    in_sample_red       <= r;
    in_sample_green     <= g;
    in_sample_blue      <= b;
    in_neighbor_pattern <= pat;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int pick_coord(int lim);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 255);
    if (sel == 1) return 0;
    if (sel == 2) return lim - 1;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int sel;
    logic [1:0] op;
    sel = $urandom_range(0, 19);
    if (sel < 9) op = OP_ACCUM;
    else if (sel < 13) op = OP_READ;
    else if (sel < 18) op = OP_NBR;
    else op = 2'($urandom_range(0, 3));
    send(op, pick_coord(cur_w), pick_coord(cur_h), pick_sample(), pick_sample(),
         pick_sample(), 2'($urandom_range(0, 3)));
  endtask

  initial begin
    int sizes_w[7];
    int sizes_h[7];
    sizes_w = '{5, 256, 1, 0, 16, 511, 2};
    sizes_h = '{4, 256, 1, 511, 16, 0, 256};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: two corners of the full image and pixels next to one, at reset size
    send(OP_ACCUM, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, PAT_ORTHO);
    send(OP_ACCUM, 255, 255, 16'h0000, 16'h1234, 16'hFFFF, PAT_ORTHO);
    send(OP_ACCUM, 0, 0, 16'h0001, 16'h8000, 16'h0000, PAT_ORTHO);
    send(OP_ACCUM, 1, 0, 16'h5555, 16'hAAAA, 16'h00FF, PAT_ORTHO);
    send(OP_ACCUM, 0, 1, 16'hAAAA, 16'h5555, 16'hFF00, PAT_ORTHO);
    send(OP_ACCUM, 1, 1, 16'h7FFF, 16'h0100, 16'h8001, PAT_ORTHO);
    send(OP_READ, 0, 0, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_READ, 255, 255, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_NBR, 0, 0, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_NBR, 0, 0, 16'h0000, 16'h0000, 16'h0000, PAT_DIAG);
    send(OP_NBR, 1, 0, 16'h0000, 16'h0000, 16'h0000, PAT_ALL);
    send(OP_NBR, 255, 255, 16'h0000, 16'h0000, 16'h0000, PAT_DIAG);

    // Directed: tiny image, out-of-range on each axis, lone pixel
    resize(3, 2);
    send(OP_ACCUM, 3, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, PAT_ORTHO);
    send(OP_READ, 0, 2, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_NBR, 255, 255, 16'h0000, 16'h0000, 16'h0000, PAT_DIAG);
    send(OP_ACCUM, 2, 1, 16'h0300, 16'h0200, 16'h0100, PAT_ORTHO);
    send(OP_NBR, 1, 1, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_NBR, 1, 0, 16'h0000, 16'h0000, 16'h0000, PAT_ALL);
    resize(1, 1);
    send(OP_ACCUM, 0, 0, 16'h1000, 16'h2000, 16'h3000, PAT_ORTHO);
    send(OP_NBR, 0, 0, 16'h0000, 16'h0000, 16'h0000, PAT_ALL);
    send(OP_ACCUM, 0, 1, 16'h1000, 16'h2000, 16'h3000, PAT_ORTHO);

    // Repeated accumulates on one pixel, run at full rate
    resize(4, 4);
    stalls_on = 1'b0;
    send(OP_ACCUM, 1, 1, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_ACCUM, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, PAT_ORTHO);
    send(OP_READ, 1, 1, 16'h0000, 16'h0000, 16'h0000, PAT_ORTHO);
    send(OP_NBR, 0, 0, 16'h0000, 16'h0000, 16'h0000, PAT_DIAG);

    // Random phases across image sizes, pacing on most of them
    for (int p = 0; p < 7; p++) begin
      resize(sizes_w[p], sizes_h[p]);
      gaps_on   = (p != 2);
      stalls_on = (p != 4);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
